// File: rtl/assert_macros.svh
// Assertion macros shared by the name validator modules.
// Each macro takes a label, a clock, an active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// File: rtl/dnv_pkg.sv
// Package for the name validator: name kinds, character codes and item types.
// No dependencies; used by every module of the block.
`default_nettype none

package dnv_pkg;

    localparam int unsigned MAX_NAME_LEN_DEF = 255;

    typedef enum logic [1:0] {
        KIND_BUS       = 2'd0,
        KIND_NAMESPACE = 2'd1,
        KIND_INTERFACE = 2'd2,
        KIND_MEMBER    = 2'd3
    } kind_t;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_byte;
        logic       has_char;
        logic       last;
    } item_t;

    typedef struct packed {
        logic is_alpha;
        logic is_digit;
        logic is_colon;
        logic is_dot;
        logic is_under;
        logic is_dash;
    } char_class_t;

endpackage

`default_nettype wire

// File: rtl/dnv_char_class.sv
// Character classifier: sorts one byte into the classes the naming rules use.
// Depends on dnv_pkg for the character codes and the class struct.
`default_nettype none

module dnv_char_class (
    input  wire logic [7:0]          char_byte,
    output dnv_pkg::char_class_t     char_class
);

    always_comb begin
        char_class.is_alpha = ((char_byte >= 8'h61) && (char_byte <= 8'h7A)) ||
                              ((char_byte >= 8'h41) && (char_byte <= 8'h5A));
        char_class.is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
        char_class.is_colon = (char_byte == dnv_pkg::CHAR_COLON);
        char_class.is_dot   = (char_byte == dnv_pkg::CHAR_DOT);
        char_class.is_under = (char_byte == dnv_pkg::CHAR_UNDER);
        char_class.is_dash  = (char_byte == dnv_pkg::CHAR_DASH);
    end

endmodule

`default_nettype wire

// File: rtl/dnv_core.sv
// Per-string state of the name validator and the verdict for the final character.
// Depends on dnv_pkg, dnv_char_class and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dnv_core #(
    parameter int unsigned MAX_NAME_LEN = dnv_pkg::MAX_NAME_LEN_DEF,
    localparam int unsigned CNT_W       = $clog2(MAX_NAME_LEN + 2)
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           item_go,
    input  wire dnv_pkg::item_t item,
    output logic                verdict
);

    localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(MAX_NAME_LEN);

    dnv_pkg::char_class_t cls;
    dnv_pkg::kind_t       kind_held_reg, kind_held_next, kind;
    logic [CNT_W-1:0]     count_reg, count_next, count_upd;
    logic                 after_dot_reg, after_dot_next, after_dot_upd;
    logic                 seen_dot_reg, seen_dot_next, seen_dot_upd;
    logic                 unique_reg, unique_next, unique_upd;
    logic                 failed_reg, failed_next, failed_upd;
    logic                 at_start_reg, at_start_next;
    logic                 bus_like, char_ok, need_dot;

    dnv_char_class u_class (
        .char_byte  (item.char_byte),
        .char_class (cls)
    );

    always_comb begin
        kind      = at_start_reg ? dnv_pkg::kind_t'(item.mode) : kind_held_reg;
        bus_like  = (kind == dnv_pkg::KIND_BUS) || (kind == dnv_pkg::KIND_NAMESPACE);
        count_upd     = count_reg;
        after_dot_upd = after_dot_reg;
        seen_dot_upd  = seen_dot_reg;
        unique_upd    = unique_reg;
        failed_upd    = failed_reg;
        char_ok = cls.is_alpha || cls.is_under ||
                  (cls.is_digit && (!after_dot_reg || (bus_like && unique_reg))) ||
                  (bus_like && cls.is_dash);

        if (item.has_char) begin
            if (count_reg <= LEN_LIMIT) begin
                count_upd = count_reg + CNT_W'(1);
            end
            if (bus_like && (count_reg == '0) && cls.is_colon) begin
                unique_upd = 1'b1;
            end else if (cls.is_dot) begin
                if ((kind == dnv_pkg::KIND_MEMBER) || after_dot_reg) begin
                    failed_upd = 1'b1;
                end
                seen_dot_upd  = 1'b1;
                after_dot_upd = 1'b1;
            end else if (char_ok) begin
                after_dot_upd = 1'b0;
            end else begin
                failed_upd = 1'b1;
            end
        end

        need_dot = (kind == dnv_pkg::KIND_BUS) || (kind == dnv_pkg::KIND_INTERFACE);
        verdict  = !failed_upd && (count_upd <= LEN_LIMIT) && !after_dot_upd &&
                   (!need_dot || seen_dot_upd);

        if (item.last) begin
            kind_held_next = dnv_pkg::KIND_BUS;
            count_next     = '0;
            after_dot_next = 1'b1;
            seen_dot_next  = 1'b0;
            unique_next    = 1'b0;
            failed_next    = 1'b0;
            at_start_next  = 1'b1;
        end else begin
            kind_held_next = kind;
            count_next     = count_upd;
            after_dot_next = after_dot_upd;
            seen_dot_next  = seen_dot_upd;
            unique_next    = unique_upd;
            failed_next    = failed_upd;
            at_start_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_held_reg <= dnv_pkg::KIND_BUS;
            count_reg     <= '0;
            after_dot_reg <= 1'b1;
            seen_dot_reg  <= 1'b0;
            unique_reg    <= 1'b0;
            failed_reg    <= 1'b0;
            at_start_reg  <= 1'b1;
        end else if (item_go) begin
            kind_held_reg <= kind_held_next;
            count_reg     <= count_next;
            after_dot_reg <= after_dot_next;
            seen_dot_reg  <= seen_dot_next;
            unique_reg    <= unique_next;
            failed_reg    <= failed_next;
            at_start_reg  <= at_start_next;
        end
    end

    `ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= LEN_LIMIT + CNT_W'(1))
    `ASSERT_NEXT(a_last_restarts, aclk, aresetn, item_go && item.last, at_start_reg)
    `ASSERT_SAME(a_start_clean, aclk, aresetn, at_start_reg,
                 (count_reg == '0) && !failed_reg && !unique_reg && !seen_dot_reg)

endmodule

`default_nettype wire

// File: rtl/dbus_name_validator.sv
// Channel  | Dir | Fields (lowest bit first)
// s_axis   | in  | tdata: char_byte[7:0]; tuser: mode[1:0], has_char[2]; tlast: last
// m_axis   | out | tdata: is_valid[0], zeros above
//
// One transaction is accepted every cycle, unless one marked last waits in the input
// register while m_axis is stalled; the per-string state in dnv_core is a feedback loop.
// m_axis_tvalid rises at the clock edge after the one that accepts the transaction
// marked last, unless an earlier verdict is still held on m_axis.
// Reset is synchronous on aresetn; there is no clearing pass.
// A stalled m_axis holds the verdict; the input register then keeps accepting
// transactions that carry no end mark.
//
// Top level of the name validator: input register, state core and result register.
// Depends on dnv_pkg, dnv_core and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dbus_name_validator #(
    parameter int unsigned MAX_NAME_LEN = dnv_pkg::MAX_NAME_LEN_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // char_byte[7:0]
    input  wire logic [2:0] s_axis_tuser,   // mode[1:0], has_char[2]
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // is_valid[0], zeros [7:1]
);

    dnv_pkg::item_t in_item_reg, in_item_next;
    logic           in_valid_reg, in_valid_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_bit_reg;
    logic           out_free, consume, verdict;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign consume       = in_valid_reg && (!in_item_reg.last || out_free);
    assign s_axis_tready = !in_valid_reg || consume;

    always_comb begin
        in_item_next.mode      = s_axis_tuser[1:0];
        in_item_next.char_byte = s_axis_tdata;
        in_item_next.has_char  = s_axis_tuser[2];
        in_item_next.last      = s_axis_tlast;
        in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        out_valid_next = out_free ? (consume && in_item_reg.last) : out_valid_reg;
    end

    dnv_core #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_go (consume),
        .item    (in_item_reg),
        .verdict (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready) begin
            in_item_reg <= in_item_next;
        end
        if (consume && in_item_reg.last) begin
            out_bit_reg <= verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_bit_reg};

    `ASSERT_NEXT(a_last_gives_result, aclk, aresetn, consume && in_item_reg.last,
                 out_valid_reg)
    `ASSERT_NEXT(a_held_item_kept, aclk, aresetn, in_valid_reg && !consume,
                 in_valid_reg && $stable(in_item_reg))
    `ASSERT_SAME(a_result_from_last, aclk, aresetn, $rose(out_valid_reg),
                 $past(consume && in_item_reg.last))

endmodule

`default_nettype wire

// File: test/dnv_checker.sv
`timescale 1ns / 1ps
// Checker for the name validator: watches both stream channels, keeps its own per-name
// state, predicts the verdict for every name and compares it with the delivered one.
// Depends on dnv_pkg for the name kinds and character codes.

module dnv_checker
    import dnv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic [2:0] s_axis_tuser,
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    output int         mismatches,
    output int         verdicts_waiting,
    output int         names_valid,
    output int         names_invalid
);

    localparam int NAME_LIMIT = MAX_NAME_LEN_DEF;

    typedef struct packed {
        kind_t      kind;
        logic [8:0] length;
        logic       seg_start;
        logic       dot_seen;
        logic       unique_name;
        logic       broken;
        logic       fresh;
    } name_state_t;

    name_state_t cur_name;
    logic        due_verdicts[$];
    int          errs = 0;
    int          n_ok = 0;
    int          n_bad = 0;

    function automatic name_state_t idle_name();
        name_state_t st;
        st.kind        = KIND_BUS;
        st.length      = '0;
        st.seg_start   = 1'b1;
        st.dot_seen    = 1'b0;
        st.unique_name = 1'b0;
        st.broken      = 1'b0;
        st.fresh       = 1'b1;
        return st;
    endfunction

    function automatic name_state_t take_byte(input name_state_t st, input logic [7:0] c);
        logic bus_like;
        logic first;
        logic alpha;
        logic digit;
        bus_like = (st.kind == KIND_BUS) || (st.kind == KIND_NAMESPACE);
        first    = (st.length == 0);
        alpha    = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        digit    = (c >= "0" && c <= "9");
        if (st.length <= NAME_LIMIT)
            st.length = st.length + 9'd1;
        if (bus_like && first && c == CHAR_COLON) begin
            st.unique_name = 1'b1;
            return st;
        end
        if (c == CHAR_DOT) begin
            if (st.kind == KIND_MEMBER || st.seg_start)
                st.broken = 1'b1;
            st.dot_seen  = 1'b1;
            st.seg_start = 1'b1;
            return st;
        end
        if (alpha || c == CHAR_UNDER || (digit && (!st.seg_start || (bus_like && st.unique_name)))
                || (bus_like && c == CHAR_DASH))
            st.seg_start = 1'b0;
        else
            st.broken = 1'b1;
        return st;
    endfunction

    function automatic logic verdict_of(input name_state_t st);
        logic ok;
        ok = !st.broken && st.length <= NAME_LIMIT && !st.seg_start;
        if (st.kind == KIND_BUS || st.kind == KIND_INTERFACE)
            ok = ok && st.dot_seen;
        return ok;
    endfunction

    task automatic flag(input string what, input logic [7:0] want, input logic [7:0] got);
        errs++;
        if (errs <= 10)
            $display("MISMATCH at %0t: %s, expected %02h, got %02h", $realtime, what, want, got);
    endtask

    always @(posedge aclk) begin
        logic want;
        if (!aresetn) begin
            cur_name = idle_name();
            due_verdicts.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_verdicts.size() == 0) begin
                    flag("verdict with no name pending", 8'h00, m_axis_tdata);
                end else begin
                    want = due_verdicts.pop_front();
                    if (m_axis_tdata[0] !== want)
                        flag("is_valid", {7'b0, want}, m_axis_tdata);
                    if (m_axis_tdata[7:1] !== 7'b0)
                        flag("padding above is_valid", {7'b0, want}, m_axis_tdata);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (cur_name.fresh) begin
                    cur_name.kind  = kind_t'(s_axis_tuser[1:0]);
                    cur_name.fresh = 1'b0;
                end
                if (s_axis_tuser[2])
                    cur_name = take_byte(cur_name, s_axis_tdata);
                if (s_axis_tlast) begin
                    want = verdict_of(cur_name);
                    due_verdicts.push_back(want);
                    if (want)
                        n_ok++;
                    else
                        n_bad++;
                    cur_name = idle_name();
                end
            end
        end
        mismatches       <= errs;
        verdicts_waiting <= due_verdicts.size();
        names_valid      <= n_ok;
        names_invalid    <= n_bad;
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Top of the name validator testbench: clock, reset, name stimulus and receiver stalls.
// Depends on dnv_pkg, dbus_name_validator and dnv_checker.

module testbench;
    import dnv_pkg::*;

    localparam int RANDOM_ITEMS = 115;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 150;

    localparam int RX_STEADY = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_MOSTLY = 2;
    localparam int RX_HOLD   = 3;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic [2:0] s_axis_tuser = '0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    int mismatches;
    int verdicts_waiting;
    int names_valid;
    int names_invalid;

    int         cycle_count = 0;
    int         items_sent = 0;
    int         burst_left = 0;
    int         hold_asks = 0;
    int         holds_done = 0;
    int         rx_mode = RX_STEADY;
    int         rx_left = 0;
    bit         scatter_blanks = 1'b0;
    logic [7:0] name_buf[$];

    dbus_name_validator dut (.*);
    dnv_checker chk (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** dbus_name_validator: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            if (holds_done != hold_asks) begin
                rx_mode = RX_HOLD;
                rx_left = HOLD_CYCLES;
                holds_done++;
            end else begin
                rx_mode = $urandom_range(RX_STEADY, RX_MOSTLY);
                rx_left = $urandom_range(4, 60);
            end
        end
        rx_left--;
        case (rx_mode)
            RX_STEADY: begin
                m_axis_tready <= 1'b1;
            end
            RX_COIN: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            RX_MOSTLY: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                m_axis_tready <= 1'b0;
            end
        endcase
    end

    task automatic offer(input kind_t mode, input logic [7:0] ch, input logic has, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0
                : $urandom_range(1, ($urandom_range(0, 9) == 0) ? 20 : 4);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                       : $urandom_range(1, 30);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= {has, mode};
        s_axis_tlast  <= fin;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_name(input kind_t k, input bit empty_end);
        int    i;
        kind_t m;
        bit    lead_blank;
        lead_blank = scatter_blanks && ($urandom_range(0, 15) == 0);
        if (name_buf.size() == 0) begin
            offer(k, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
            return;
        end
        if (lead_blank)
            offer(k, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
        for (i = 0; i < name_buf.size(); i++) begin
            m = (i == 0 && !lead_blank) ? k : kind_t'($urandom_range(0, 3));
            if (i > 0 && scatter_blanks && $urandom_range(0, 15) == 0)
                offer(m, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            offer(m, name_buf[i], 1'b1, !empty_end && i == name_buf.size() - 1);
        end
        if (empty_end)
            offer(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic send_text(input kind_t k, input string txt);
        int i;
        name_buf.delete();
        for (i = 0; i < txt.len(); i++)
            name_buf.push_back(txt[i]);
        send_name(k, 1'b0);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (verdicts_waiting != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_char(input bit lead, input bit digit_lead,
                                             input bit dash_ok);
        int r;
        r = $urandom_range(0, 9);
        if (r <= 3)
            return "a" + 8'($urandom_range(0, 25));
        if (r <= 5)
            return "A" + 8'($urandom_range(0, 25));
        if (r == 6)
            return CHAR_UNDER;
        if (r <= 8)
            return (lead && !digit_lead) ? "q" : "0" + 8'($urandom_range(0, 9));
        return dash_ok ? CHAR_DASH : CHAR_UNDER;
    endfunction

    task automatic build_wellformed(input kind_t k);
        bit bus_like;
        bit uniq;
        int segs;
        int len;
        int s;
        int j;
        name_buf.delete();
        bus_like = (k == KIND_BUS) || (k == KIND_NAMESPACE);
        uniq     = bus_like && ($urandom_range(0, 2) == 0);
        if (uniq)
            name_buf.push_back(CHAR_COLON);
        segs = (k == KIND_MEMBER) ? 1 : $urandom_range(1, 4);
        for (s = 0; s < segs; s++) begin
            if (s > 0)
                name_buf.push_back(CHAR_DOT);
            len = $urandom_range(1, 8);
            for (j = 0; j < len; j++)
                name_buf.push_back(pick_char(j == 0, uniq, bus_like));
        end
    endtask

    task automatic mutate();
        int pos;
        pos = $urandom_range(0, name_buf.size());
        case ($urandom_range(0, 6))
            0: name_buf.insert(pos, 8'($urandom_range(0, 255)));
            1: name_buf.insert(pos, CHAR_DOT);
            2: name_buf.insert(pos, CHAR_COLON);
            3: name_buf.push_back(CHAR_DOT);
            4: name_buf.insert(0, "0" + 8'($urandom_range(0, 9)));
            5: if (name_buf.size() > 0) name_buf.delete($urandom_range(0, name_buf.size() - 1));
            default: name_buf.insert(pos, CHAR_DASH);
        endcase
    endtask

    task automatic build_noise();
        int len;
        int j;
        name_buf.delete();
        len = $urandom_range(0, 6);
        for (j = 0; j < len; j++)
            name_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_long(input int n);
        name_buf.delete();
        name_buf.push_back("x");
        name_buf.push_back(CHAR_DOT);
        while (name_buf.size() < n)
            name_buf.push_back("a" + 8'($urandom_range(0, 25)));
    endtask

    initial begin
        kind_t k;
        int    start_items;
        int    nth;
        int    r;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty names of every kind, then short names for each rule.
        send_text(KIND_BUS, "");
        send_text(KIND_NAMESPACE, "");
        send_text(KIND_INTERFACE, "");
        send_text(KIND_MEMBER, "");
        send_text(KIND_BUS, ":1.2");
        send_text(KIND_INTERFACE, "a.b");
        send_text(KIND_MEMBER, "x-y");
        send_text(KIND_NAMESPACE, "a:");
        send_text(KIND_NAMESPACE, "9");
        send_text(KIND_BUS, "a.");
        send_text(KIND_MEMBER, ".");
        offer(KIND_NAMESPACE, 8'hFF, 1'b1, 1'b1);
        // The kind comes from a leading item without a character.
        offer(KIND_MEMBER, 8'h00, 1'b0, 1'b0);
        offer(KIND_BUS, "a", 1'b1, 1'b1);
        drain();

        scatter_blanks = 1'b1;
        start_items = items_sent;
        nth = 0;
        while (items_sent < start_items + RANDOM_ITEMS) begin
            if (nth == 1 || nth == 7)
                hold_asks <= hold_asks + 1;
            if (nth == 4)
                drain();
            k = kind_t'($urandom_range(0, 3));
            r = $urandom_range(0, 19);
            if (r < 13) begin
                build_wellformed(k);
            end else if (r < 17) begin
                build_wellformed(k);
                mutate();
            end else begin
                build_noise();
            end
            send_name(k, $urandom_range(0, 7) == 0);
            nth++;
        end

        // Names at and past the length limit; the longer one drives the counter into
        // saturation.
        build_long(MAX_NAME_LEN_DEF);
        send_name(KIND_INTERFACE, 1'b0);
        build_long(MAX_NAME_LEN_DEF + 2);
        send_name(KIND_INTERFACE, 1'b1);

        drain();
        repeat (8) @(posedge aclk);
        $display("Checked %0d names (%0d valid, %0d invalid) over %0d transactions.",
                 names_valid + names_invalid, names_valid, names_invalid, items_sent);
        $display("Covered all four kinds, unique names, stray bytes, empty ends and overlong names.");
        if (mismatches == 0 && verdicts_waiting == 0) begin
            $display("** dbus_name_validator: PASSED **");
        end else begin
            $display("** dbus_name_validator: FAILED **");
        end
        $finish;
    end

endmodule
